FILE: src/skl_pkg.sv
// Shared types and constants for the sorted key list.
// No dependencies; used by skl_ctrl, skl_dp and sorted_key_list.
package skl_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  typedef struct packed {
    logic first;
    logic search;
    logic do_insert;
    logic do_delete;
    logic use_saved;
    logic load_out;
  } cmd_t;

endpackage

FILE: src/skl_ctrl.sv
// Controller FSM for the sorted key list: input/output handshake and datapath commands.
// Depends on skl_pkg.
module skl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_operation,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output skl_pkg::cmd_t       cmd
);

  skl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == skl_pkg::S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      skl_pkg::S_IDLE: begin
        if (accept) begin
          cmd.first = 1'b1;
          unique case (skl_pkg::op_t'(in_operation))
            skl_pkg::OP_INSERT: begin
              cmd.do_insert = 1'b1;
              cmd.load_out  = 1'b1;
            end
            skl_pkg::OP_LOOKUP: begin
              cmd.search   = 1'b1;
              cmd.load_out = 1'b1;
            end
            skl_pkg::OP_DELETE: begin
              cmd.search    = 1'b1;
              cmd.do_delete = 1'b1;
              cmd.load_out  = 1'b1;
            end
            skl_pkg::OP_UPDATE: begin
              cmd.search    = 1'b1;
              cmd.do_delete = 1'b1;
              state_nxt     = skl_pkg::S_UPD;
            end
            default: ;
          endcase
        end
      end
      skl_pkg::S_UPD: begin
        cmd.do_insert = 1'b1;
        cmd.use_saved = 1'b1;
        cmd.load_out  = 1'b1;
        state_nxt     = skl_pkg::S_IDLE;
      end
      default: state_nxt = skl_pkg::S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

endmodule

FILE: src/skl_dp.sv
// Datapath for the sorted key list: row of key cells with parallel compare and
// shift for insert/delete, plus the result register. Depends on skl_pkg.
module skl_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  skl_pkg::cmd_t                        cmd,
  input  logic signed [skl_pkg::KEY_WIDTH-1:0] in_key,
  input  logic signed [skl_pkg::KEY_WIDTH-1:0] in_new_key,
  output logic                                 out_found,
  output logic [skl_pkg::POS_W-1:0]            out_position,
  output logic                                 out_full_res,
  output logic [skl_pkg::COUNT_W-1:0]          out_count
);

  logic signed [skl_pkg::KEY_WIDTH-1:0] keys_r [skl_pkg::CAPACITY];
  logic signed [skl_pkg::KEY_WIDTH-1:0] nk_r;
  logic signed [skl_pkg::KEY_WIDTH-1:0] key_sel;
  logic [skl_pkg::CNT_W-1:0]            count_r, count_nxt;
  logic [skl_pkg::CAPACITY-1:0]         vld, lt, hit, lt_ext;
  logic [skl_pkg::IDX_W-1:0]            hit_idx;
  logic                                 found, full, ins_en, del_en;
  logic                                 f_r;
  logic [skl_pkg::IDX_W-1:0]            p_r;
  logic                                 out_found_r, out_full_r;
  logic [skl_pkg::POS_W-1:0]            out_pos_r;
  logic [skl_pkg::COUNT_W-1:0]          out_count_r;

  assign key_sel = cmd.use_saved ? nk_r : in_key;
  assign lt_ext  = {lt[skl_pkg::CAPACITY-2:0], 1'b1};

  for (genvar g = 0; g < skl_pkg::CAPACITY; g++) begin : g_cell
    logic signed [skl_pkg::KEY_WIDTH-1:0] up_src, dn_src;

    assign vld[g] = skl_pkg::CNT_W'(g) < count_r;
    assign lt[g]  = vld[g] && (keys_r[g] < key_sel);
    assign hit[g] = vld[g] && (keys_r[g] == key_sel) && lt_ext[g];

    if (g == 0) begin : g_first
      assign up_src = key_sel;
    end else begin : g_mid
      assign up_src = lt_ext[g] ? key_sel : keys_r[g-1];
    end

    if (g == skl_pkg::CAPACITY - 1) begin : g_last
      assign dn_src = keys_r[g];
    end else begin : g_body
      assign dn_src = keys_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ins_en && !lt[g]) begin
        keys_r[g] <= up_src;
      end else if (del_en && !lt[g]) begin
        keys_r[g] <= dn_src;
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < skl_pkg::CAPACITY; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | skl_pkg::IDX_W'(i);
      end
    end
  end

  assign found  = |hit;
  assign full   = count_r == skl_pkg::CNT_W'(skl_pkg::CAPACITY);
  assign ins_en = cmd.do_insert && !full;
  assign del_en = cmd.do_delete && found;

  always_comb begin
    count_nxt = count_r;
    if (ins_en) begin
      count_nxt = count_r + skl_pkg::CNT_W'(1);
    end else if (del_en) begin
      count_nxt = count_r - skl_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // update keeps its search result and new key for the insert step
  always_ff @(posedge clk) begin
    if (cmd.first) begin
      nk_r <= in_new_key;
      f_r  <= cmd.search && found;
      p_r  <= (cmd.search && found) ? hit_idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.first) begin
        out_found_r <= cmd.search && found;
        out_pos_r   <= (cmd.search && found) ? skl_pkg::POS_W'(hit_idx) : '0;
      end else begin
        out_found_r <= f_r;
        out_pos_r   <= skl_pkg::POS_W'(p_r);
      end
      out_full_r  <= cmd.do_insert && full;
      out_count_r <= skl_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_found    = out_found_r;
  assign out_position = out_pos_r;
  assign out_full_res = out_full_r;
  assign out_count    = out_count_r;

endmodule

FILE: src/sorted_key_list.sv
// Top level of the sorted key list: controller plus cell-row datapath.
// Depends on skl_pkg, skl_ctrl and skl_dp.
//
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_stall    | in_operation, in_key, in_new_key
// out_    | output    | out_valid / out_stall  | out_found, out_position, out_full_res, out_count
//
// Insert, lookup and delete are done in state S_IDLE; update does its delete there, then its insert in S_UPD.
// The row of key cells compares all entries and shifts in the same cycle; update uses it twice.
// Synchronous active-low reset empties the list; key cells are not cleared.
// in_stall is high during the insert step of an update (S_UPD) and while a result is held by out_stall.
module sorted_key_list (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_operation,
  input  logic signed [skl_pkg::KEY_WIDTH-1:0] in_key,
  input  logic signed [skl_pkg::KEY_WIDTH-1:0] in_new_key,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [skl_pkg::POS_W-1:0]            out_position,
  output logic                                 out_full_res,
  output logic [skl_pkg::COUNT_W-1:0]          out_count
);

  skl_pkg::cmd_t cmd;

  skl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  skl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_key       (in_key),
    .in_new_key   (in_new_key),
    .out_found    (out_found),
    .out_position (out_position),
    .out_full_res (out_full_res),
    .out_count    (out_count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= skl_pkg::COUNT_W'(skl_pkg::CAPACITY)))
    else $error("result count above capacity");

  a_update_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == skl_pkg::OP_UPDATE)) |=> in_stall)
    else $error("update not held for its insert step");

  a_no_dual_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_insert && cmd.do_delete))
    else $error("insert and delete in one cycle");

  a_full_only_if_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_full_res && out_found))
    else $error("refused insert after a successful delete");
`endif

endmodule

FILE: tb/sorted_key_list_tb.sv
// Self-checking testbench for sorted_key_list: directed table, then phased random traffic.
// Results are predicted by an in-bench sorted-list model; depends on skl_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_key_list_tb;
  import skl_pkg::*;

  localparam int ITEMS_RANDOM = 1650;
  localparam int PHASE_LEN    = 150;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_LEN     = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIRECTED   = 27;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic               full_res;
    logic [COUNT_W-1:0] count;
  } list_res_t;

  typedef struct packed {
    op_t                          op;
    logic signed [KEY_WIDTH-1:0]  key;
    logic signed [KEY_WIDTH-1:0]  new_key;
    logic                         fixed;
    list_res_t                    res;
  } stim_row_t;

  localparam list_res_t NO_RES = '0;

  // fixed rows carry a result read straight off the spec; the rest use the predictor
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_LOOKUP, 32'sd0,        32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
    '{OP_UPDATE, 32'sd7,        KEY_MIN,  1'b1, '{1'b0, 4'd0, 1'b0, 5'd1}},
    '{OP_INSERT, KEY_MAX,       32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd2}},
    '{OP_INSERT, KEY_MIN,       32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd3}},
    '{OP_INSERT, KEY_MAX,       32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd4}},
    '{OP_LOOKUP, KEY_MAX,       32'sd0,   1'b1, '{1'b1, 4'd2, 1'b0, 5'd4}},
    '{OP_DELETE, KEY_MIN,       32'sd0,   1'b1, '{1'b1, 4'd0, 1'b0, 5'd3}},
    '{OP_DELETE, KEY_MAX,       32'sd0,   1'b1, '{1'b1, 4'd1, 1'b0, 5'd2}},
    '{OP_DELETE, KEY_MAX,       32'sd0,   1'b1, '{1'b1, 4'd1, 1'b0, 5'd1}},
    '{OP_DELETE, 32'sd5,        32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd1}},
    '{OP_INSERT, -32'sd1,       32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd0,        32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd1,        32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd100,      32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, -32'sd100,     32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sh55555555, 32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'shAAAAAAAA, 32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd5,        32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd5,        32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, -32'sd7,       32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sd12345,    32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sh7FFFFFFE, 32'sd0,   1'b0, NO_RES},
    '{OP_INSERT, 32'sh80000001, 32'sd0,   1'b0, NO_RES},
    '{OP_UPDATE, 32'sd999,      32'sd42,  1'b0, NO_RES},
    '{OP_INSERT, 32'sd3,        32'sd0,   1'b1, '{1'b0, 4'd0, 1'b0, 5'd16}},
    '{OP_UPDATE, 32'sd888,      32'sd1,   1'b1, '{1'b0, 4'd0, 1'b1, 5'd16}},
    '{OP_UPDATE, 32'sd5,        KEY_MAX,  1'b0, NO_RES}
  };

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_operation;
  logic signed [KEY_WIDTH-1:0] in_key;
  logic signed [KEY_WIDTH-1:0] in_new_key;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_found;
  logic [POS_W-1:0]            out_position;
  logic                        out_full_res;
  logic [COUNT_W-1:0]          out_count;

  logic                        cur_fixed;
  list_res_t                   cur_fixed_res;
  bit                          no_idle = 1'b0;

  logic signed [KEY_WIDTH-1:0] list_keys [CAPACITY];
  int                          list_len = 0;
  list_res_t                   pending_results [$];
  logic signed [KEY_WIDTH-1:0] key_pool [8];
  int                          mismatches = 0;
  int                          cycles = 0;

  sorted_key_list i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_new_key   (in_new_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .out_full_res (out_full_res),
    .out_count    (out_count)
  );

  always #2 clk = ~clk;

  function automatic bit list_find(logic signed [KEY_WIDTH-1:0] k, output int idx);
    int i;
    i = 0;
    while (i < list_len && list_keys[i] < k) i++;
    idx = 0;
    if (i < list_len && list_keys[i] == k) begin
      idx = i;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit list_insert(logic signed [KEY_WIDTH-1:0] k);
    int i;
    if (list_len >= CAPACITY) return 1'b0;
    i = 0;
    while (i < list_len && list_keys[i] < k) i++;
    for (int j = list_len; j > i; j--) list_keys[j] = list_keys[j-1];
    list_keys[i] = k;
    list_len++;
    return 1'b1;
  endfunction

  function automatic void list_remove(int idx);
    for (int j = idx; j < list_len - 1; j++) list_keys[j] = list_keys[j+1];
    list_len--;
  endfunction

  function automatic list_res_t apply_list_op(op_t op, logic signed [KEY_WIDTH-1:0] k,
                                              logic signed [KEY_WIDTH-1:0] nk);
    list_res_t r;
    int        idx;
    r   = '0;
    idx = 0;
    case (op)
      OP_INSERT: r.full_res = !list_insert(k);
      OP_LOOKUP: r.found = list_find(k, idx);
      OP_DELETE: begin
        r.found = list_find(k, idx);
        if (r.found) list_remove(idx);
      end
      default: begin
        r.found = list_find(k, idx);
        if (r.found) list_remove(idx);
        r.full_res = !list_insert(nk);
      end
    endcase
    r.position = r.found ? idx[POS_W-1:0] : '0;
    r.count    = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic bit gap_roll();
    return !no_idle && ($urandom_range(99) < 14);
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return key_pool[$urandom_range(7)];
    if (r < 80) begin
      case ($urandom_range(3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  task automatic send_item(op_t op, logic signed [KEY_WIDTH-1:0] k,
                           logic signed [KEY_WIDTH-1:0] nk, logic fixed, list_res_t res);
    while (gap_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_key        <= k;
    in_new_key    <= nk;
    cur_fixed     <= fixed;
    cur_fixed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor
    list_res_t want;
    list_res_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = apply_list_op(op_t'(in_operation), in_key, in_new_key);
        pending_results.push_back(cur_fixed ? cur_fixed_res : want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_found, out_position, out_full_res, out_count};
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0b pos=%0d full=%0b count=%0d",
                                  got.found, got.position, got.full_res, got.count));
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found || got.position !== want.position ||
              got.full_res !== want.full_res || got.count !== want.count) begin
            note_mismatch($sformatf(
              "exp found=%0b pos=%0d full=%0b count=%0d, got found=%0b pos=%0d full=%0b count=%0d",
              want.found, want.position, want.full_res, want.count,
              got.found, got.position, got.full_res, got.count));
          end
        end
      end
    end
  end

  initial begin : receiver
    int rx_cycle;
    rx_cycle  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= gap_roll();
      end
    end
  end

  initial begin : sender
    op_t op;
    int  mode;
    int  r;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_INSERT;
    in_key        <= '0;
    in_new_key    <= '0;
    cur_fixed     <= 1'b0;
    cur_fixed_res <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].new_key,
                DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);
    end

    // phases cycle through fill, drain and mixed traffic over a small key pool
    for (int n = 0; n < ITEMS_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        mode = (n / PHASE_LEN) % 3;
        if (mode == 0) begin
          foreach (key_pool[p]) begin
            if ($urandom_range(1)) key_pool[p] = $urandom;
            else key_pool[p] = $signed($urandom_range(20)) - 10;
          end
        end
      end
      no_idle = (n >= 600 && n < 900);
      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 55) ? OP_INSERT : (r < 70) ? OP_UPDATE : (r < 85) ? OP_LOOKUP
                                                                           : OP_DELETE;
        1:       op = (r < 10) ? OP_INSERT : (r < 25) ? OP_UPDATE : (r < 45) ? OP_LOOKUP
                                                                           : OP_DELETE;
        default: op = op_t'(r % 4);
      endcase
      send_item(op, pick_key(), ($urandom_range(3) == 0) ? $urandom : pick_key(), 1'b0, '0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
